[rtl/svfs_pkg.sv]
package svfs_pkg;

   // frame geometry
   localparam int BULK_VOICES        = 32;
   localparam int PACKED_VOICE_BYTES = 128;
   localparam int SINGLE_LONG_BYTES  = 155;
   localparam int BULK_BYTES         = BULK_VOICES * PACKED_VOICE_BYTES;
   localparam int VOICE_SHIFT        = $clog2(PACKED_VOICE_BYTES);

   localparam int COUNT_W = 13;
   localparam int VOICE_W = 5;
   localparam int INDEX_W = 8;
   localparam int SUM_W   = 7;

   // header and trailer bytes
   localparam logic [7:0] SYSEX_START  = 8'hF0;
   localparam logic [7:0] MAKER_ID     = 8'h43;
   localparam logic [7:0] CHANNEL_ZERO = 8'h00;
   localparam logic [7:0] BULK_TAG     = 8'h09;
   localparam logic [7:0] BULK_SIZE_HI = 8'h20;
   localparam logic [7:0] BULK_SIZE_LO = 8'h00;
   localparam logic [7:0] SINGLE_TAG   = 8'h00;
   localparam logic [7:0] SINGLE_HI    = 8'h01;
   localparam logic [7:0] SINGLE_LO    = 8'h1B;
   localparam logic [7:0] END_MARK     = 8'hF7;

   // frame format codes
   localparam logic [1:0] FMT_BULK   = 2'd0;
   localparam logic [1:0] FMT_SINGLE = 2'd1;
   localparam logic [1:0] FMT_PACKED = 2'd2;

   localparam logic RESULT_PAYLOAD = 1'b0;
   localparam logic RESULT_VERDICT = 1'b1;

   typedef enum logic [1:0] {
      MODE_SEARCH = 2'd0,
      MODE_BULK   = 2'd1,
      MODE_SINGLE = 2'd2,
      MODE_PACKED = 2'd3
   } scan_mode_type;

   // index 0 is the oldest byte
   typedef logic [4:0][7:0] window_type;

   typedef struct packed {
      logic               kind;
      logic [7:0]         data;
      logic [1:0]         format;
      logic [VOICE_W-1:0] voice;
      logic [INDEX_W-1:0] index;
      logic               checksum_ok;
      logic               end_mark_ok;
      logic               frame_ok;
   } result_type;

   function automatic logic [COUNT_W-1:0] payload_len(input logic [1:0] fmt);
      logic [COUNT_W-1:0] len;
      case (fmt)
         FMT_BULK:   len = COUNT_W'(BULK_BYTES);
         FMT_SINGLE: len = COUNT_W'(SINGLE_LONG_BYTES);
         default:    len = COUNT_W'(PACKED_VOICE_BYTES);
      endcase
      return len;
   endfunction

endpackage

[rtl/sysex_voice_frame_scanner.sv]
// Channel  Direction  Ports                                         Handshake
// req      in         req_in_byte, req_end_of_stream                req_valid/req_ready
// rsp      out        rsp_result_kind, rsp_data_byte, rsp_frame_format,
//                     rsp_voice_index, rsp_byte_index, rsp_checksum_ok,
//                     rsp_end_mark_ok, rsp_frame_ok                 rsp_valid/rsp_ready
//
// One word per cycle sustained while req_ready stays high.
// The rate is set by the update of the frame counter, checksum and
// header window, which every word needs before the next.
// Reset (synchronous, active high) returns to search with an empty window.
// Results pass through an output register backed by a skid register, so input is
// taken while one result waits; req_ready drops only when both are full.
module sysex_voice_frame_scanner
   import svfs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,

   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_in_byte,
   input  logic         req_end_of_stream,

   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic         rsp_result_kind,
   output logic [7:0]   rsp_data_byte,
   output logic [1:0]   rsp_frame_format,
   output logic [4:0]   rsp_voice_index,
   output logic [7:0]   rsp_byte_index,
   output logic         rsp_checksum_ok,
   output logic         rsp_end_mark_ok,
   output logic         rsp_frame_ok
);

   // scanner state
   window_type         window_ff, window_in;
   scan_mode_type      mode_ff, mode_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic               csm_ff, csm_in;

   // output register and skid stage
   result_type         out_ff, out_in;
   logic               out_valid_ff, out_valid_in;
   result_type         skid_ff, skid_in;
   logic               skid_valid_ff, skid_valid_in;

   logic               accept;
   logic               out_free;
   scan_mode_type      match;
   result_type         res;
   logic               res_valid;
   logic [1:0]         fmt;
   logic [COUNT_W-1:0] len;
   logic [7:0]         expected_cs;
   logic               end_mark;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign out_free  = !out_valid_ff || rsp_ready;

   svfs_header_match u_match (
      .window  (window_ff),
      .in_byte (req_in_byte),
      .match   (match)
   );

   assign fmt         = 2'(mode_ff) - 2'd1;
   assign len         = payload_len(fmt);
   // (128 - sum) mod 128, compared over all eight bits
   assign expected_cs = {1'b0, SUM_W'(0) - sum_ff};
   assign end_mark    = (req_in_byte == END_MARK);

   always_comb begin
      window_in = window_ff;
      mode_in   = mode_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      csm_in    = csm_ff;
      res       = '0;
      res_valid = 1'b0;

      if (accept) begin
         if (mode_ff == MODE_SEARCH) begin
            if (match != MODE_SEARCH) begin
               mode_in   = match;
               count_in  = '0;
               sum_in    = '0;
               csm_in    = 1'b0;
               window_in = '0;
            end else begin
               window_in = {req_in_byte, window_ff[4:1]};
            end
         end else if (count_ff < len) begin
            // payload word
            res.kind   = RESULT_PAYLOAD;
            res.data   = req_in_byte;
            res.format = fmt;
            if (fmt == FMT_BULK) begin
               res.voice = count_ff[VOICE_SHIFT +: VOICE_W];
               res.index = INDEX_W'(count_ff[VOICE_SHIFT-1:0]);
            end else begin
               res.index = count_ff[INDEX_W-1:0];
            end
            res_valid = 1'b1;
            sum_in    = sum_ff + req_in_byte[SUM_W-1:0];
            count_in  = count_ff + COUNT_W'(1);
         end else if (count_ff == len) begin
            // checksum word: checked, no result
            csm_in   = (req_in_byte == expected_cs);
            count_in = count_ff + COUNT_W'(1);
         end else begin
            // closing word: verdict
            res.kind        = RESULT_VERDICT;
            res.format      = fmt;
            res.checksum_ok = csm_ff;
            res.end_mark_ok = end_mark;
            res.frame_ok    = csm_ff && end_mark;
            res_valid       = 1'b1;
            mode_in         = MODE_SEARCH;
            count_in        = '0;
            sum_in          = '0;
            csm_in          = 1'b0;
         end

         // last word of the stream: back to reset state after handling it
         if (req_end_of_stream) begin
            window_in = '0;
            mode_in   = MODE_SEARCH;
            count_in  = '0;
            sum_in    = '0;
            csm_in    = 1'b0;
         end
      end
   end

   // result routing: skid drains first, it is only filled when the output holds
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = res;
            out_valid_in = res_valid;
         end
      end else if (res_valid) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff     <= '0;
         mode_ff       <= MODE_SEARCH;
         count_ff      <= '0;
         sum_ff        <= '0;
         csm_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         window_ff     <= window_in;
         mode_ff       <= mode_in;
         count_ff      <= count_in;
         sum_ff        <= sum_in;
         csm_ff        <= csm_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_kind  = out_ff.kind;
   assign rsp_data_byte    = out_ff.data;
   assign rsp_frame_format = out_ff.format;
   assign rsp_voice_index  = out_ff.voice;
   assign rsp_byte_index   = out_ff.index;
   assign rsp_checksum_ok  = out_ff.checksum_ok;
   assign rsp_end_mark_ok  = out_ff.end_mark_ok;
   assign rsp_frame_ok     = out_ff.frame_ok;

endmodule

[rtl/svfs_header_match.sv]
module svfs_header_match
   import svfs_pkg::*;
(
   input  window_type    window,
   input  logic [7:0]    in_byte,
   output scan_mode_type match
);

   logic prefix;

   assign prefix = (window[0] == SYSEX_START) && (window[1] == MAKER_ID) &&
                   (window[2] == CHANNEL_ZERO);

   // bulk is tested first: it also fits the packed pattern
   always_comb begin
      match = MODE_SEARCH;
      if (prefix) begin
         if (window[3] == BULK_TAG && window[4] == BULK_SIZE_HI &&
             in_byte == BULK_SIZE_LO) begin
            match = MODE_BULK;
         end else if (window[3] == SINGLE_TAG && window[4] == SINGLE_HI &&
                      in_byte == SINGLE_LO) begin
            match = MODE_SINGLE;
         end else if (window[3] == BULK_TAG) begin
            match = MODE_PACKED;
         end
      end
   end

endmodule
